FILE: hdl/sts_pkg.sv
// Shared types for the Taylor-series sine block: word structs, sequencer
// states and the status struct of the serial arithmetic units. No dependencies.
package sts_pkg;

  typedef struct packed {
    logic signed [27:0] x_value;
    logic [4:0]         term_count;
  } sts_in_t;

  typedef struct packed {
    logic signed [31:0] sine_value;
    logic               saturated;
  } sts_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_TSTART,
    ST_TMUL,
    ST_TDIV,
    ST_FIN
  } sts_state_t;

endpackage

FILE: hdl/sine_taylor_series_top.sv
// Top level of the Taylor-series sine block: sequencer, term and sum
// registers, output register. Depends on sts_pkg, sts_mul and sts_div.
//
// Usage:
//   Input channel (in_valid/in_stall/in_word) takes one word: angle x in
//   signed fixed point (clamped to +/-4.0) and term count n (clamped to
//   MAX_TERMS). Output channel (out_valid/out_stall/out_word) returns one
//   word per input: the series sum saturated to 32 bits plus a clip flag.
//   One item is in work at a time; in_stall is high from acceptance until
//   the result is loaded into the output register.
//   Each item squares x on the serial multiplier, then per term runs the
//   multiplier and then the serial divider, then loads the output register.
//   TW = FRAC_BITS+5 is the multiplier operand width and QW = FRAC_BITS+10
//   the divider quotient width. The single shared multiplier and divider
//   work one bit per cycle.
//   The output register holds a finished word while out_stall is high; a
//   new item is accepted meanwhile and only its final load waits.
//   Reset (rst_n low, synchronous) drops any item in work and the output.
module sine_taylor_series_top import sts_pkg::*; #(
  parameter int MAX_TERMS = 16,
  parameter int FRAC_BITS = 24
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sts_in_t  in_word,
  output logic     out_valid,
  input  logic     out_stall,
  output sts_out_t out_word
);

  localparam int TW = FRAC_BITS + 5;
  localparam int PW = 2 * TW;
  localparam int QW = PW - FRAC_BITS;
  localparam int SW = (FRAC_BITS + 8 > 34) ? FRAC_BITS + 8 : 34;
  localparam int NW = $clog2(MAX_TERMS + 1);
  localparam int DW = $clog2(2 * MAX_TERMS * (2 * MAX_TERMS + 1) + 1);
  localparam logic signed [SW-1:0] LIMIT   = SW'(64'd4 << FRAC_BITS);
  localparam logic signed [SW-1:0] SAT_MAX = SW'(64'h7FFF_FFFF);
  localparam logic signed [SW-1:0] SAT_MIN = -SW'(64'h8000_0000);

  sts_state_t state_r, state_nxt;

  logic [TW-1:0]        x2_r,  x2_nxt;
  logic [TW-1:0]        mag_r, mag_nxt;
  logic                 neg_r, neg_nxt;
  logic signed [SW-1:0] sum_r, sum_nxt;
  logic [NW-1:0]        j_r,   j_nxt;
  logic [NW-1:0]        n_r,   n_nxt;
  logic [DW-1:0]        d_r,   d_nxt;
  logic                 out_valid_r;
  sts_out_t             out_word_r;
  logic                 out_load;

  logic                 mul_start;
  logic [TW-1:0]        mul_a, mul_b;
  logic [PW-1:0]        mul_prod;
  unit_stat_t           mul_stat;
  logic                 div_start;
  logic [QW-1:0]        div_dividend;
  logic [QW-1:0]        div_quot;
  unit_stat_t           div_stat;

  logic signed [SW-1:0] x_ext, x_clamp, x_abs;
  logic                 prod_rest;

  sts_mul #(.W(TW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mul_stat),
    .prod  (mul_prod)
  );

  sts_div #(.QW(QW), .DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (d_r),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  // Clamp the incoming angle to +/-4.0 and take its magnitude.
  always_comb begin
    x_ext = SW'(in_word.x_value);
    priority if (x_ext > LIMIT) begin
      x_clamp = LIMIT;
    end else if (x_ext < -LIMIT) begin
      x_clamp = -LIMIT;
    end else begin
      x_clamp = x_ext;
    end
    x_abs = (x_clamp < 0) ? -x_clamp : x_clamp;
  end

  // Bits shifted out of the product decide the floor of a negative term.
  assign prod_rest    = |mul_prod[FRAC_BITS-1:0];
  assign div_dividend = mul_prod[PW-1:FRAC_BITS] + QW'(neg_r & prod_rest);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    x2_r  <= x2_nxt;
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    sum_r <= sum_nxt;
    j_r   <= j_nxt;
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    if (out_load) begin
      priority if (sum_r > SAT_MAX) begin
        out_word_r.sine_value <= 32'sh7FFF_FFFF;
        out_word_r.saturated  <= 1'b1;
      end else if (sum_r < SAT_MIN) begin
        out_word_r.sine_value <= 32'sh8000_0000;
        out_word_r.saturated  <= 1'b1;
      end else begin
        out_word_r.sine_value <= sum_r[31:0];
        out_word_r.saturated  <= 1'b0;
      end
    end
  end

  // Sequencer: square x, then per term multiply by x2 and divide by (2j)(2j+1).
  always_comb begin
    state_nxt = state_r;
    x2_nxt    = x2_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    sum_nxt   = sum_r;
    j_nxt     = j_r;
    n_nxt     = n_r;
    d_nxt     = d_r;
    mul_start = 1'b0;
    mul_a     = mag_r;
    mul_b     = x2_r;
    div_start = 1'b0;
    out_load  = 1'b0;
    in_stall  = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mag_nxt   = TW'(x_abs);
          neg_nxt   = (x_clamp < 0);
          sum_nxt   = x_clamp;
          j_nxt     = '0;
          d_nxt     = '0;
          if (int'(in_word.term_count) > MAX_TERMS) begin
            n_nxt = NW'(MAX_TERMS);
          end else begin
            n_nxt = NW'(in_word.term_count);
          end
          mul_start = 1'b1;
          mul_a     = TW'(x_abs);
          mul_b     = TW'(x_abs);
          state_nxt = ST_SQR;
        end
      end
      ST_SQR: begin
        if (mul_stat.done) begin
          x2_nxt    = mul_prod[FRAC_BITS +: TW];
          state_nxt = ST_TSTART;
        end
      end
      ST_TSTART: begin
        if (j_r == n_r) begin
          state_nxt = ST_FIN;
        end else begin
          // (2j)(2j+1) grows by 8j-2 from one term to the next.
          j_nxt     = j_r + NW'(1);
          d_nxt     = d_r + DW'(8 * (int'(j_r) + 1) - 2);
          mul_start = 1'b1;
          state_nxt = ST_TMUL;
        end
      end
      ST_TMUL: begin
        if (mul_stat.done) begin
          div_start = 1'b1;
          state_nxt = ST_TDIV;
        end
      end
      ST_TDIV: begin
        if (div_stat.done) begin
          mag_nxt   = TW'(div_quot);
          neg_nxt   = !neg_r && (div_quot != '0);
          sum_nxt   = neg_r ? sum_r + SW'(div_quot) : sum_r - SW'(div_quot);
          state_nxt = ST_TSTART;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_stat.busy && div_stat.busy))
    else $error("multiplier and divider busy together");

  a_idle_units_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!mul_stat.busy && !div_stat.busy))
    else $error("arithmetic unit busy while idle");

  a_term_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (j_r <= n_r))
    else $error("term index past term count");

  a_fin_waits_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && out_stall) |=> (state_r == ST_FIN))
    else $error("result load overran a held output word");

endmodule

FILE: hdl/sts_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on sts_pkg for the unit status struct.
module sts_mul import sts_pkg::*; #(
  parameter int W = 29
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output unit_stat_t     stat,
  output logic [2*W-1:0] prod
);

  localparam int CW = $clog2(W + 1);

  logic [2*W-1:0] acc_r;
  logic [2*W-1:0] sa_r;
  logic [W-1:0]   sb_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r;
  logic           done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      sa_r  <= {{W{1'b0}}, a};
      sb_r  <= b;
      cnt_r <= CW'(W);
    end else if (busy_r) begin
      if (sb_r[0]) begin
        acc_r <= acc_r + sa_r;
      end
      sa_r  <= {sa_r[2*W-2:0], 1'b0};
      sb_r  <= {1'b0, sb_r[W-1:1]};
      cnt_r <= cnt_r - CW'(1);
    end
  end

  assign prod      = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: hdl/sts_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on sts_pkg for the unit status struct.
module sts_div import sts_pkg::*; #(
  parameter int QW = 34,
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [QW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output unit_stat_t    stat,
  output logic [QW-1:0] quotient
);

  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem_r;
  logic [QW-1:0] quo_r;
  logic [DW-1:0] dv_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  assign trial = {rem_r, quo_r[QW-1]};
  assign diff  = trial - {1'b0, dv_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dv_r  <= divisor;
      cnt_r <= CW'(QW);
    end else if (busy_r) begin
      if (!diff[DW]) begin
        rem_r <= diff[DW-1:0];
        quo_r <= {quo_r[QW-2:0], 1'b1};
      end else begin
        rem_r <= trial[DW-1:0];
        quo_r <= {quo_r[QW-2:0], 1'b0};
      end
      cnt_r <= cnt_r - CW'(1);
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: dv/tb_sine_taylor_series_top.sv
// Self-checking testbench for sine_taylor_series_top: drives angle/term-count
// words, predicts each truncated sine series sum and checks the result words.
// Depends on sts_pkg and the block's RTL.
module tb_sine_taylor_series_top;
  import sts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_TERMS = 16;
  localparam int FRAC_BITS = 24;
  localparam longint XLIM = longint'(4) << FRAC_BITS;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  sts_in_t  in_word = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  sts_out_t out_word;

  sts_out_t sine_expected_q[$];
  int       mismatches = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;

  always #4 clk = ~clk;

  sine_taylor_series_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  // Exact floor((a*b) >> FRAC_BITS); rest flags any dropped bits.
  function automatic longint unsigned mul_floor(longint unsigned a, longint unsigned b,
                                                output bit rest);
    logic [127:0] prod;
    prod = 128'(a) * 128'(b);
    rest = |prod[FRAC_BITS-1:0];
    return prod[FRAC_BITS+63:FRAC_BITS];
  endfunction

  function automatic sts_out_t sine_series(sts_in_t w);
    longint x, term, sum;
    longint unsigned xmag, x2, q, d;
    int n;
    bit rest;
    sts_out_t r;
    x = longint'(w.x_value);
    if (x > XLIM) x = XLIM;
    if (x < -XLIM) x = -XLIM;
    n = (w.term_count > MAX_TERMS) ? MAX_TERMS : int'(w.term_count);
    xmag = (x < 0) ? longint'(-x) : x;
    x2 = mul_floor(xmag, xmag, rest);
    term = x;
    sum = x;
    for (int j = 1; j <= n; j++) begin
      d = longint'(2 * j) * longint'(2 * j + 1);
      if (term < 0) begin
        q = mul_floor(longint'(-term), x2, rest);
        if (rest) q += 1;  // floor of a negative product rounds away
        term = longint'(q / d);
      end else begin
        q = mul_floor(term, x2, rest);
        term = -longint'(q / d);
      end
      sum += term;
    end
    r.saturated = 1'b0;
    if (sum > 64'sd2147483647) begin
      sum = 64'sd2147483647;
      r.saturated = 1'b1;
    end
    if (sum < -64'sd2147483648) begin
      sum = -64'sd2147483648;
      r.saturated = 1'b1;
    end
    r.sine_value = sum[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Send one word: random gap first, then hold valid until accepted.
  task automatic send_word(logic signed [27:0] x, logic [4:0] n);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{x_value: x, term_count: n};
    sine_expected_q.push_back(sine_series('{x_value: x, term_count: n}));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // Keep valid high if another word follows at once; the next gap or drain lowers it.
  endtask

  // Receiver: stall at random and check each accepted result word.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (sine_expected_q.size() == 0) begin
        report_mismatch("unexpected word", out_word.sine_value, 0);
      end else begin
        sts_out_t want;
        want = sine_expected_q.pop_front();
        if (out_word.sine_value !== want.sine_value)
          report_mismatch("sine_value", out_word.sine_value, want.sine_value);
        if (out_word.saturated !== want.saturated)
          report_mismatch("saturated", out_word.saturated, want.saturated);
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic drain();
    in_valid <= 1'b0;
    while (sine_expected_q.size() != 0) @(posedge clk);
  endtask

  // Angles at and beyond the +/-4.0 clamp, zero, tiny values; term counts from 0 to past MAX_TERMS.
  task automatic test_directed();
    send_word(28'sd0, 5'd16);
    send_word(28'sd67108864, 5'd16);
    send_word(-28'sd67108864, 5'd16);
    send_word(28'sh7FFFFFF, 5'd31);
    send_word(-28'sh8000000, 5'd31);
    send_word(28'sd1, 5'd5);
    send_word(-28'sd1, 5'd5);
    send_word(28'sd26353589, 5'd0);
    send_word(-28'sd26353589, 5'd0);
    send_word(28'sd52707179, 5'd17);
    send_word(-28'sd52707179, 5'd1);
    send_word(28'sd16777216, 5'd2);
    send_word(-28'sd16777216, 5'd3);
    send_word(28'sd67108863, 5'd8);
    send_word(-28'sd67108865, 5'd24);
    drain();
  endtask

  // Mostly in-range angles, some beyond the clamp; mostly small term counts.
  task automatic test_random(int count);
    logic signed [27:0] x;
    logic [4:0] n;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) x = 28'($urandom);
      else x = 28'($signed($urandom_range(134217728)) - 67108864);
      n = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(4));
      send_word(x, n);
    end
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 33;
    recv_idle_pct = 80;
    test_directed();
    test_random(330);
    send_idle_pct = 80;
    recv_idle_pct = 33;
    test_random(330);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(340);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && sine_expected_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Safety net: fails the run if the test sequence hangs.
  initial begin
    #40ms;
    $display("Verification failed");
    $finish;
  end
endmodule

FILE: filelist.f
hdl/sts_pkg.sv
hdl/sts_mul.sv
hdl/sts_div.sv
hdl/sine_taylor_series_top.sv
dv/tb_sine_taylor_series_top.sv
